FILE: rtl/core/cmac_pkg.sv
package cmac_pkg;

  localparam int BlockW = 128;
  localparam int HalfW = 64;
  localparam int CountW = 5;
  localparam int Rounds = 10;
  localparam int RkDepth = Rounds + 1;
  localparam int RkAddrW = $clog2(RkDepth);
  localparam logic [7:0] DblPoly = 8'h87;
  localparam logic [7:0] GfPoly = 8'h1b;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [CountW-1:0] FullCount = 5'd16;

  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow = 1'b1;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

  // byte i of a 128-bit block sits at bits [127-8i -: 8]
  function automatic logic [7:0] byte_of(input logic [BlockW-1:0] v, input int i);
    return v[BlockW-1-8*i -: 8];
  endfunction

  // SubBytes, ShiftRows and (unless final) MixColumns; round key added outside
  function automatic logic [BlockW-1:0] aes_round(input logic [BlockW-1:0] s,
                                                  input logic final_rnd);
    logic [7:0] t [16];
    logic [7:0] u [16];
    logic [7:0] a0, a1, a2, a3;
    logic [BlockW-1:0] r;
    for (int i = 0; i < 16; i++) t[i] = sbox(byte_of(s, i));
    for (int i = 0; i < 4; i++)
      for (int c = 0; c < 4; c++) u[i + 4*c] = t[i + 4*((c + i) % 4)];
    if (!final_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
        u[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        u[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        u[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        u[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int i = 0; i < 16; i++) r[BlockW-1-8*i -: 8] = u[i];
    return r;
  endfunction

  // next round key from previous one
  function automatic logic [BlockW-1:0] key_step(input logic [BlockW-1:0] k,
                                                 input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [BlockW-1:0] dbl(input logic [BlockW-1:0] v);
    return {v[BlockW-2:0], 1'b0} ^ {{(BlockW-8){1'b0}}, (v[BlockW-1] ? DblPoly : 8'h00)};
  endfunction

endpackage

FILE: rtl/core/aes128_cmac_engine.sv
// AES-128 CMAC tag engine.
// Config: write key_high (index 0) and key_low (index 1) via cfg_we/cfg_index/cfg_data
// while idle. The key is sampled only on the first transaction after reset; a later
// key change needs a reset.
// Input channel (in_valid/in_stall): one 16-byte message block per transaction, with
// valid_bytes and last_block. Non-last blocks are chained as full blocks.
// Output channel (out_valid/out_stall): one tag per message, after the last block.
// Round keys live in an 11-entry synchronous RAM with a registered read; the
// round loop reads key r+1 while round r runs, so one AES round per cycle.
// Sequence: a non-last block goes from acceptance through the initial key add
// (BREAD) and 10 rounds (BRUN) back to idle, one block at a time. On a last
// block the tag is loaded into the output register and flagged valid via EMIT,
// and the next block can go in once the tag is taken. The first block after
// reset adds key expansion (EXPAND) and encryption of the zero block for the
// subkeys (LREAD, LRUN).
// Reset clears the chain, the subkey-ready flag and all handshake state.
// A stalled tag stays in the output register and the input stalls until the
// tag is taken.
module aes128_cmac_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [63:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [63:0]                block_high,
  input  logic [63:0]                block_low,
  input  logic [4:0]                 valid_bytes,
  input  logic                       last_block,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [63:0]                tag_high,
  output logic [63:0]                tag_low
);
  import cmac_pkg::*;

  typedef enum logic [2:0] {IDLE, EXPAND, LREAD, LRUN, BREAD, BRUN, EMIT} state_t;
  state_t state;

  logic [HalfW-1:0] key_high, key_low;
  logic [BlockW-1:0] rk_mem [RkDepth];
  logic [BlockW-1:0] rk_rd;
  logic [RkAddrW-1:0] rd_addr;
  logic [RkAddrW-1:0] cnt;
  logic [BlockW-1:0] ekey;
  logic [7:0] rcon;
  logic [BlockW-1:0] st, chain, k1, k2, pend;
  logic pend_last, ready;
  logic pend_full;
  logic [BlockW-1:0] msg, padded, rnd_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegKeyHigh) key_high <= cfg_data;
      else key_low <= cfg_data;
    end
  end

  // round key RAM
  always_ff @(posedge clk) begin
    if (state == EXPAND) rk_mem[cnt] <= ekey;
    rk_rd <= rk_mem[rd_addr];
  end

  assign in_stall = (state != IDLE) || out_valid;

  // padding of the last block
  always_comb begin
    msg = {block_high, block_low};
    padded = msg;
    for (int i = 0; i < 16; i++) begin
      if (i[4:0] == valid_bytes) padded[BlockW-1-8*i -: 8] = PadByte;
      else if (i[4:0] > valid_bytes) padded[BlockW-1-8*i -: 8] = 8'h00;
    end
  end

  assign rnd_out = aes_round(st, cnt == RkAddrW'(Rounds)) ^ rk_rd;

  // prefetch the key for the next cycle; wrap to key 0 after the final round
  always_comb begin
    rd_addr = '0;
    if (state == LREAD || state == LRUN || state == BREAD || state == BRUN) begin
      if (cnt == RkAddrW'(Rounds)) rd_addr = '0;
      else rd_addr = cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      ready <= 1'b0;
      chain <= '0;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        IDLE: if (in_valid && !in_stall) begin
          pend_last <= last_block;
          if (!last_block) pend <= msg;
          else pend <= (valid_bytes >= FullCount) ? msg : padded;
          cnt <= '0;
          if (!ready) begin
            ekey <= {key_high, key_low};
            rcon <= 8'h01;
            state <= EXPAND;
          end else state <= BREAD;
        end
        EXPAND: begin
          ekey <= key_step(ekey, rcon);
          rcon <= xtime(rcon);
          if (cnt == RkAddrW'(Rounds)) begin
            cnt <= '0;
            state <= LREAD;
          end else cnt <= cnt + 1'b1;
        end
        LREAD: begin
          st <= '0 ^ rk_rd;
          cnt <= cnt + 1'b1;
          state <= LRUN;
        end
        LRUN: begin
          st <= rnd_out;
          if (cnt == RkAddrW'(Rounds)) begin
            k1 <= dbl(rnd_out);
            k2 <= dbl(dbl(rnd_out));
            ready <= 1'b1;
            cnt <= '0;
            state <= BREAD;
          end else cnt <= cnt + 1'b1;
        end
        BREAD: begin
          if (pend_last)
            st <= chain ^ pend ^ ((pend_full) ? k1 : k2) ^ rk_rd;
          else st <= chain ^ pend ^ rk_rd;
          cnt <= cnt + 1'b1;
          state <= BRUN;
        end
        BRUN: begin
          st <= rnd_out;
          if (cnt == RkAddrW'(Rounds)) begin
            cnt <= '0;
            if (pend_last) begin
              chain <= '0;
              {tag_high, tag_low} <= rnd_out;
              state <= EMIT;
            end else begin
              chain <= rnd_out;
              state <= IDLE;
            end
          end else cnt <= cnt + 1'b1;
        end
        EMIT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // full-block flag, captured with the block
  always_ff @(posedge clk) begin
    if (state == IDLE && in_valid && !in_stall) pend_full <= (valid_bytes >= FullCount);
  end

endmodule

FILE: rtl/core/cmac_checker.sv
module cmac_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [63:0] tag_high,
  input logic [63:0] tag_low
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tag_high) && $stable(tag_low))
    else $error("tag changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted two blocks back to back");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("tag valid after reset");
endmodule

bind aes128_cmac_engine cmac_checker u_chk (.*);
